[hdl/wsd_pkg.sv]
// shared types and constants for the wave stream decoder
package wsd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned DIV_STEPS = 32;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [15:0] FMT_PCM = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;
	localparam logic [15:0] FMT_HEAD_BYTES = 16'd16;
	localparam logic [15:0] MAX_DEPTH = 16'd32;
	localparam logic [7:0] PCM8_OFFSET = 8'h80;

	typedef enum logic [3:0] {
		PH_RIFF,
		PH_RIFFSIZE,
		PH_WAVE,
		PH_FMTID,
		PH_FMTSIZE,
		PH_FORMAT,
		PH_CHANNELS,
		PH_RATE,
		PH_BYTERATE,
		PH_ALIGN,
		PH_BITS,
		PH_SKIP,
		PH_CHUNKID,
		PH_CHUNKSIZE,
		PH_DATASIZE,
		PH_SAMPLES
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_NOT_RIFF = 3'd1,
		ERR_NOT_WAVE = 3'd2,
		ERR_DEPTH_OVER = 3'd3,
		ERR_NO_DATA = 3'd4,
		ERR_BAD_DEPTH = 3'd5,
		ERR_BAD_FORMAT = 3'd6
	} err_t;

	// one request from the parser to the output side
	typedef struct packed {
		kind_t kind;
		err_t err;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [31:0] frame;
		logic [31:0] raw;
		logic [1:0] len_m1;
		logic is_float;
		logic last;
	} rec_t;

endpackage

[hdl/wsd_in_if.sv]
// byte stream channel into the decoder
interface wsd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic first_byte;
	logic end_of_stream;

	modport source (output valid, output data_byte, output first_byte, output end_of_stream,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input end_of_stream,
		output ready);
endinterface

[hdl/wsd_out_if.sv]
// result channel out of the decoder
interface wsd_out_if;
	logic valid;
	logic ready;
	logic [1:0] result_kind;
	logic [2:0] error_code;
	logic [15:0] channel_total;
	logic [31:0] rate_hz;
	logic [31:0] frame_total;
	logic [15:0] channel_index;
	logic [31:0] frame_index;
	logic signed [31:0] pcm_value;
	logic [31:0] float_bits;
	logic is_float;
	logic last_sample;

	modport source (output valid, output result_kind, output error_code, output channel_total,
		output rate_hz, output frame_total, output channel_index, output frame_index,
		output pcm_value, output float_bits, output is_float, output last_sample,
		input ready);
	modport sink (input valid, input result_kind, input error_code, input channel_total,
		input rate_hz, input frame_total, input channel_index, input frame_index,
		input pcm_value, input float_bits, input is_float, input last_sample,
		output ready);
endinterface

[hdl/wave_stream_decoder.sv]
// wave stream decoder top level: parser, request queue, output stage
// path: a result passes through the request queue and then the output register;
//   the header waits for the divider to finish before it takes the same path
// throughput: one byte per cycle while the queue has room; the byte that completes the
//   data size holds the input while the divider finds the frame count one bit per cycle
// reset: parser expects a riff tag, queue and output register are empty
module wave_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	wsd_in_if.sink    stream,
	wsd_out_if.source result
);
	import wsd_pkg::*;

	logic push_valid;
	logic push_ready;
	rec_t push_rec;
	logic pop_valid;
	logic pop_ready;
	rec_t pop_rec;

	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec)
	);

	wsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_rec   (pop_rec),
		.result    (result)
	);
endmodule

[hdl/wsd_div.sv]
// iterative restoring divider, one quotient bit per cycle
module wsd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [31:0] quo
);
	import wsd_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;

	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic q_bit;

	assign rem_sh = {rem_q[15:0], quo_q[31]};
	assign q_bit = rem_sh >= {1'b0, den_q};
	assign rem_sub = q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
			cnt_q <= CNT_W'(DIV_STEPS);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], q_bit};
			rem_q <= rem_sub;
			cnt_q <= cnt_q - CNT_W'(1);
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	assign done = !busy_q;
	assign quo = quo_q;
endmodule

[hdl/wsd_front.sv]
// chunk parser: takes bytes, tracks the file layout and issues requests
module wsd_front (
	input  logic          clk,
	input  logic          arst_n,
	wsd_in_if.sink        stream,
	output logic          push_valid,
	input  logic          push_ready,
	output wsd_pkg::rec_t push_rec
);
	import wsd_pkg::*;

	phase_t ph_q, ph_d, ph_e;
	logic [1:0] bif_q, bif_d, bif_e;
	logic [31:0] fs_q, fs_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] chans_q, chans_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] depth_q, depth_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] frames_q, frames_d;
	logic [15:0] ch_now_q, ch_now_d;
	logic [31:0] fr_now_q, fr_now_d;
	logic div_wait_q, div_wait_d;
	logic eos_pend_q, eos_pend_d;

	logic accept;
	logic [2:0] len;
	logic [31:0] field_new;
	logic fdone;
	logic smp_active;
	logic take_en;
	logic [31:0] skip_trim;
	logic [31:0] skip_dec;
	logic res_valid;
	kind_t res_kind;
	err_t res_err;
	logic res_last;
	logic hdr_start;
	logic go_idle;
	logic div_done;
	logic [31:0] div_quo;
	logic [31:0] frames_div;

	assign accept = stream.valid && stream.ready;
	assign ph_e = stream.first_byte ? PH_RIFF : ph_q;
	assign bif_e = stream.first_byte ? 2'd0 : bif_q;

	always_comb begin
		case (ph_e)
			PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS: len = 3'd2;
			PH_SAMPLES: len = (fmt_q == FMT_FLOAT) ? 3'd4 : depth_q[5:3];
			default: len = 3'd4;
		endcase
	end

	assign field_new = ((bif_e == 2'd0) ? 32'd0 : fs_q) | ({24'd0, stream.data_byte} << {bif_e, 3'b000});
	assign fdone = ({1'b0, bif_e} + 3'd1) >= len;
	assign smp_active = (chans_q != 16'd0) && (fr_now_q < frames_q);
	assign take_en = (ph_e != PH_SKIP) && !((ph_e == PH_SAMPLES) && !smp_active);
	assign skip_trim = (skip_q > {16'd0, FMT_HEAD_BYTES}) ? (skip_q - {16'd0, FMT_HEAD_BYTES}) : 32'd0;
	assign skip_dec = (skip_q != 32'd0) ? (skip_q - 32'd1) : skip_q;
	assign frames_div = (align_q == 16'd0) ? 32'd0 : div_quo;

	wsd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hdr_start),
		.num    (field_new),
		.den    (align_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// next state
	always_comb begin
		ph_d = ph_q;
		bif_d = bif_q;
		fs_d = fs_q;
		fmt_d = fmt_q;
		chans_d = chans_q;
		rate_d = rate_q;
		align_d = align_q;
		depth_d = depth_q;
		skip_d = skip_q;
		frames_d = frames_q;
		ch_now_d = ch_now_q;
		fr_now_d = fr_now_q;
		div_wait_d = div_wait_q;
		eos_pend_d = eos_pend_q;
		res_valid = 1'b0;
		res_kind = KIND_ERROR;
		res_err = ERR_NONE;
		res_last = 1'b0;
		hdr_start = 1'b0;
		go_idle = 1'b0;
		if (div_wait_q) begin
			if (div_done && push_ready) begin
				div_wait_d = 1'b0;
				frames_d = eos_pend_q ? 32'd0 : frames_div;
				ch_now_d = '0;
				fr_now_d = '0;
			end
		end else if (accept) begin
			ph_d = ph_e;
			bif_d = bif_e;
			if (take_en) begin
				bif_d = fdone ? 2'd0 : (bif_e + 2'd1);
				fs_d = field_new;
			end
			case (ph_e)
				PH_RIFF: begin
					if (fdone) begin
						if (field_new != TAG_RIFF) begin
							res_valid = 1'b1;
							res_err = ERR_NOT_RIFF;
						end else begin
							ph_d = PH_RIFFSIZE;
						end
					end
				end
				PH_RIFFSIZE: begin
					if (fdone) ph_d = PH_WAVE;
				end
				PH_WAVE: begin
					if (fdone) begin
						if (field_new != TAG_WAVE) begin
							res_valid = 1'b1;
							res_err = ERR_NOT_WAVE;
						end else begin
							ph_d = PH_FMTID;
						end
					end
				end
				PH_FMTID: begin
					if (fdone) ph_d = PH_FMTSIZE;
				end
				PH_FMTSIZE: begin
					if (fdone) begin
						skip_d = field_new;
						ph_d = PH_FORMAT;
					end
				end
				PH_FORMAT: begin
					if (fdone) begin
						fmt_d = field_new[15:0];
						ph_d = PH_CHANNELS;
					end
				end
				PH_CHANNELS: begin
					if (fdone) begin
						chans_d = field_new[15:0];
						ph_d = PH_RATE;
					end
				end
				PH_RATE: begin
					if (fdone) begin
						rate_d = field_new;
						ph_d = PH_BYTERATE;
					end
				end
				PH_BYTERATE: begin
					if (fdone) ph_d = PH_ALIGN;
				end
				PH_ALIGN: begin
					if (fdone) begin
						align_d = field_new[15:0];
						ph_d = PH_BITS;
					end
				end
				PH_BITS: begin
					if (fdone) begin
						depth_d = field_new[15:0];
						if (field_new[15:0] > MAX_DEPTH) begin
							res_valid = 1'b1;
							res_err = ERR_DEPTH_OVER;
						end else begin
							skip_d = skip_trim;
							ph_d = (skip_trim != 32'd0) ? PH_SKIP : PH_CHUNKID;
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 32'd0) ph_d = PH_CHUNKID;
				end
				PH_CHUNKID: begin
					if (fdone) ph_d = (field_new == TAG_DATA) ? PH_DATASIZE : PH_CHUNKSIZE;
				end
				PH_CHUNKSIZE: begin
					if (fdone) begin
						skip_d = field_new;
						ph_d = (field_new != 32'd0) ? PH_SKIP : PH_CHUNKID;
					end
				end
				PH_DATASIZE: begin
					if (fdone) begin
						if ((fmt_q == FMT_PCM) &&
							!(depth_q inside {16'd8, 16'd16, 16'd24, 16'd32})) begin
							res_valid = 1'b1;
							res_err = ERR_BAD_DEPTH;
						end else if ((fmt_q != FMT_PCM) && (fmt_q != FMT_FLOAT)) begin
							res_valid = 1'b1;
							res_err = ERR_BAD_FORMAT;
						end else begin
							hdr_start = 1'b1;
							div_wait_d = 1'b1;
							eos_pend_d = stream.end_of_stream;
							ph_d = PH_SAMPLES;
							frames_d = '0;
							ch_now_d = '0;
							fr_now_d = '0;
						end
					end
				end
				PH_SAMPLES: begin
					if (smp_active && fdone) begin
						res_valid = 1'b1;
						res_kind = KIND_SAMPLE;
						res_last = (fr_now_q == (frames_q - 32'd1)) &&
							(ch_now_q == (chans_q - 16'd1));
						if (({1'b0, ch_now_q} + 17'd1) >= {1'b0, chans_q}) begin
							ch_now_d = '0;
							fr_now_d = fr_now_q + 32'd1;
						end else begin
							ch_now_d = ch_now_q + 16'd1;
						end
					end
				end
				default: ph_d = ph_e;
			endcase
			if (stream.end_of_stream) begin
				if (!res_valid && !hdr_start && (ph_d != PH_SAMPLES)) begin
					res_valid = 1'b1;
					res_kind = KIND_ERROR;
					res_err = ERR_NO_DATA;
				end
				go_idle = 1'b1;
			end
			if (res_valid && (res_kind == KIND_ERROR)) go_idle = 1'b1;
			if (go_idle) begin
				ph_d = PH_SAMPLES;
				frames_d = '0;
				ch_now_d = '0;
				fr_now_d = '0;
				bif_d = 2'd0;
			end
		end
	end

	// outputs
	always_comb begin
		push_valid = 1'b0;
		push_rec = '0;
		if (div_wait_q) begin
			push_valid = div_done;
			push_rec.kind = KIND_HEADER;
			push_rec.chan = chans_q;
			push_rec.rate = rate_q;
			push_rec.frame = frames_div;
		end else if (res_valid) begin
			push_valid = 1'b1;
			push_rec.kind = res_kind;
			if (res_kind == KIND_SAMPLE) begin
				push_rec.chan = ch_now_q;
				push_rec.frame = fr_now_q;
				push_rec.raw = field_new;
				push_rec.len_m1 = 2'(len - 3'd1);
				push_rec.is_float = fmt_q == FMT_FLOAT;
				push_rec.last = res_last;
			end else begin
				push_rec.err = res_err;
			end
		end
		stream.ready = !div_wait_q && push_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_RIFF;
			bif_q <= '0;
			fs_q <= '0;
			fmt_q <= '0;
			chans_q <= '0;
			rate_q <= '0;
			align_q <= '0;
			depth_q <= '0;
			skip_q <= '0;
			frames_q <= '0;
			ch_now_q <= '0;
			fr_now_q <= '0;
			div_wait_q <= 1'b0;
			eos_pend_q <= 1'b0;
		end else begin
			ph_q <= ph_d;
			bif_q <= bif_d;
			fs_q <= fs_d;
			fmt_q <= fmt_d;
			chans_q <= chans_d;
			rate_q <= rate_d;
			align_q <= align_d;
			depth_q <= depth_d;
			skip_q <= skip_d;
			frames_q <= frames_d;
			ch_now_q <= ch_now_d;
			fr_now_q <= fr_now_d;
			div_wait_q <= div_wait_d;
			eos_pend_q <= eos_pend_d;
		end
	end
endmodule

[hdl/wsd_fifo.sv]
// short request queue between parser and output stage
module wsd_fifo #(
	parameter int unsigned DEPTH = wsd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  wsd_pkg::rec_t push_rec,
	output logic          pop_valid,
	input  logic          pop_ready,
	output wsd_pkg::rec_t pop_rec
);
	import wsd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rec_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid = cnt_q != CNT_W'(0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_rec = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : (wr_q + PTR_W'(1));
			if (do_pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : (rd_q + PTR_W'(1));
			if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end
endmodule

[hdl/wsd_back.sv]
// output stage: formats requests into results and holds them for the sink
module wsd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  wsd_pkg::rec_t pop_rec,
	wsd_out_if.source     result
);
	import wsd_pkg::*;

	logic valid_q;
	logic [1:0] kind_q;
	logic [2:0] err_q;
	logic [15:0] ch_tot_q;
	logic [31:0] rate_q;
	logic [31:0] fr_tot_q;
	logic [15:0] ch_idx_q;
	logic [31:0] fr_idx_q;
	logic [31:0] pcm_q;
	logic [31:0] flt_q;
	logic is_flt_q;
	logic last_q;

	logic [31:0] pcm_fix;
	logic is_hdr;
	logic is_smp;

	assign pop_ready = !valid_q || result.ready;
	assign is_hdr = pop_rec.kind == KIND_HEADER;
	assign is_smp = pop_rec.kind == KIND_SAMPLE;

	// left-justify to q1.31, 8-bit data is offset binary
	always_comb begin
		case (pop_rec.len_m1)
			2'd0: pcm_fix = {pop_rec.raw[7:0] ^ PCM8_OFFSET, 24'd0};
			2'd1: pcm_fix = {pop_rec.raw[15:0], 16'd0};
			2'd2: pcm_fix = {pop_rec.raw[23:0], 8'd0};
			default: pcm_fix = pop_rec.raw;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			kind_q <= pop_rec.kind;
			err_q <= pop_rec.err;
			ch_tot_q <= is_hdr ? pop_rec.chan : 16'd0;
			rate_q <= is_hdr ? pop_rec.rate : 32'd0;
			fr_tot_q <= is_hdr ? pop_rec.frame : 32'd0;
			ch_idx_q <= is_smp ? pop_rec.chan : 16'd0;
			fr_idx_q <= is_smp ? pop_rec.frame : 32'd0;
			pcm_q <= (is_smp && !pop_rec.is_float) ? pcm_fix : 32'd0;
			flt_q <= (is_smp && pop_rec.is_float) ? pop_rec.raw : 32'd0;
			is_flt_q <= is_smp && pop_rec.is_float;
			last_q <= is_smp && pop_rec.last;
		end
	end

	assign result.valid = valid_q;
	assign result.result_kind = kind_q;
	assign result.error_code = err_q;
	assign result.channel_total = ch_tot_q;
	assign result.rate_hz = rate_q;
	assign result.frame_total = fr_tot_q;
	assign result.channel_index = ch_idx_q;
	assign result.frame_index = fr_idx_q;
	assign result.pcm_value = signed'(pcm_q);
	assign result.float_bits = flt_q;
	assign result.is_float = is_flt_q;
	assign result.last_sample = last_q;
endmodule

[dv/wave_stream_decoder_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the wave stream decoder: wave files in as bytes, results checked
module wave_stream_decoder_tb;
	import wsd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic first;
		logic eos;
	} byte_req_t;

	typedef struct packed {
		kind_t kind;
		err_t err;
		logic [15:0] chan_total;
		logic [31:0] rate;
		logic [31:0] frames;
		logic [15:0] chan_idx;
		logic [31:0] frame_idx;
		logic [31:0] pcm;
		logic [31:0] fbits;
		logic isf;
		logic last;
	} wave_result_t;

	typedef struct packed {
		logic [15:0] fmt;
		logic [15:0] nch;
		logic [31:0] rate;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] fmt_size;
		int chunks;
		logic [31:0] data_size;
		int payload;
		int tag_break;
		int cut;
		bit eos;
	} wav_spec_t;

	logic clk = 1'b0;
	logic arst_n;

	wsd_in_if stream_ch ();
	wsd_out_if result_ch ();

	wave_stream_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_ch),
		.result(result_ch)
	);

	always #6 clk = ~clk;

	byte_req_t pending_bytes[$];
	wave_result_t awaited_results[$];
	logic [7:0] file_bytes[$];

	int total_bytes = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int error_count = 0;
	logic byte_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_marks = 0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;

	// decoder state mirror
	phase_t stage;
	logic [1:0] field_pos;
	logic [31:0] field_acc;
	logic [15:0] fmt_code;
	logic [15:0] chan_cnt;
	logic [31:0] rate_val;
	logic [15:0] align_cnt;
	logic [15:0] depth_bits;
	logic [31:0] skip_cnt;
	logic [31:0] frame_cnt;
	logic [15:0] chan_at;
	logic [31:0] frame_at;

	function automatic void clear_parser();
		stage = PH_RIFF;
		field_pos = '0;
		field_acc = '0;
		fmt_code = '0;
		chan_cnt = '0;
		rate_val = '0;
		align_cnt = '0;
		depth_bits = '0;
		skip_cnt = '0;
		frame_cnt = '0;
		chan_at = '0;
		frame_at = '0;
	endfunction

	function automatic void idle_parser();
		stage = PH_SAMPLES;
		frame_cnt = '0;
		frame_at = '0;
		chan_at = '0;
		field_pos = '0;
		field_acc = '0;
	endfunction

	function automatic bit gather(input logic [7:0] b, input int unsigned len);
		int unsigned k;
		k = field_pos;
		if (k == 0)
			field_acc = '0;
		field_acc = field_acc | (32'(b) << (8 * k));
		if (k + 1 >= len) begin
			field_pos = '0;
			return 1'b1;
		end
		field_pos = 2'(k + 1);
		return 1'b0;
	endfunction

	function automatic wave_result_t fault(input err_t code);
		wave_result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.err = code;
		idle_parser();
		return r;
	endfunction

	task automatic parse_byte(input logic [7:0] b, output bit got, output wave_result_t r);
		int unsigned len;
		got = 1'b0;
		r = '0;
		case (stage)
			PH_RIFF: if (gather(b, 4)) begin
				if (field_acc != TAG_RIFF) begin
					r = fault(ERR_NOT_RIFF);
					got = 1'b1;
				end else begin
					stage = PH_RIFFSIZE;
				end
			end
			PH_RIFFSIZE: if (gather(b, 4))
				stage = PH_WAVE;
			PH_WAVE: if (gather(b, 4)) begin
				if (field_acc != TAG_WAVE) begin
					r = fault(ERR_NOT_WAVE);
					got = 1'b1;
				end else begin
					stage = PH_FMTID;
				end
			end
			PH_FMTID: if (gather(b, 4))
				stage = PH_FMTSIZE;
			PH_FMTSIZE: if (gather(b, 4)) begin
				skip_cnt = field_acc;
				stage = PH_FORMAT;
			end
			PH_FORMAT: if (gather(b, 2)) begin
				fmt_code = field_acc[15:0];
				stage = PH_CHANNELS;
			end
			PH_CHANNELS: if (gather(b, 2)) begin
				chan_cnt = field_acc[15:0];
				stage = PH_RATE;
			end
			PH_RATE: if (gather(b, 4)) begin
				rate_val = field_acc;
				stage = PH_BYTERATE;
			end
			PH_BYTERATE: if (gather(b, 4))
				stage = PH_ALIGN;
			PH_ALIGN: if (gather(b, 2)) begin
				align_cnt = field_acc[15:0];
				stage = PH_BITS;
			end
			PH_BITS: if (gather(b, 2)) begin
				depth_bits = field_acc[15:0];
				if (depth_bits > MAX_DEPTH) begin
					r = fault(ERR_DEPTH_OVER);
					got = 1'b1;
				end else begin
					skip_cnt = (skip_cnt > 32'(FMT_HEAD_BYTES)) ?
						skip_cnt - 32'(FMT_HEAD_BYTES) : '0;
					stage = (skip_cnt != 0) ? PH_SKIP : PH_CHUNKID;
				end
			end
			PH_SKIP: begin
				if (skip_cnt != 0)
					skip_cnt = skip_cnt - 32'd1;
				if (skip_cnt == 0)
					stage = PH_CHUNKID;
			end
			PH_CHUNKID: if (gather(b, 4))
				stage = (field_acc == TAG_DATA) ? PH_DATASIZE : PH_CHUNKSIZE;
			PH_CHUNKSIZE: if (gather(b, 4)) begin
				skip_cnt = field_acc;
				stage = (skip_cnt != 0) ? PH_SKIP : PH_CHUNKID;
			end
			PH_DATASIZE: if (gather(b, 4)) begin
				if (fmt_code == FMT_PCM && depth_bits != 8 && depth_bits != 16 &&
						depth_bits != 24 && depth_bits != 32) begin
					r = fault(ERR_BAD_DEPTH);
					got = 1'b1;
				end else if (fmt_code != FMT_PCM && fmt_code != FMT_FLOAT) begin
					r = fault(ERR_BAD_FORMAT);
					got = 1'b1;
				end else begin
					frame_cnt = (align_cnt != 0) ? field_acc / 32'(align_cnt) : '0;
					frame_at = '0;
					chan_at = '0;
					stage = PH_SAMPLES;
					got = 1'b1;
					r.kind = KIND_HEADER;
					r.chan_total = chan_cnt;
					r.rate = rate_val;
					r.frames = frame_cnt;
				end
			end
			default: begin
				if (chan_cnt != 0 && frame_at < frame_cnt) begin
					len = (fmt_code == FMT_FLOAT) ? 4 : depth_bits / 8;
					if (gather(b, len)) begin
						got = 1'b1;
						r.kind = KIND_SAMPLE;
						r.chan_idx = chan_at;
						r.frame_idx = frame_at;
						if (fmt_code == FMT_FLOAT) begin
							r.fbits = field_acc;
							r.isf = 1'b1;
						end else begin
							case (len)
								1: r.pcm = {field_acc[7:0] ^ PCM8_OFFSET, 24'h0};
								2: r.pcm = {field_acc[15:0], 16'h0};
								3: r.pcm = {field_acc[23:0], 8'h0};
								default: r.pcm = field_acc;
							endcase
						end
						r.last = (frame_at == frame_cnt - 32'd1) &&
							(chan_at == 16'(chan_cnt - 16'd1));
						if (32'(chan_at) + 32'd1 >= 32'(chan_cnt)) begin
							chan_at = '0;
							frame_at = frame_at + 32'd1;
						end else begin
							chan_at = chan_at + 16'd1;
						end
					end
				end
			end
		endcase
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic first, input logic eos);
		bit got;
		wave_result_t r;
		if (first)
			clear_parser();
		parse_byte(b, got, r);
		if (eos) begin
			if (!got && stage != PH_SAMPLES) begin
				r = fault(ERR_NO_DATA);
				got = 1'b1;
			end
			idle_parser();
		end
		if (got)
			awaited_results.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	task automatic put_le(input logic [31:0] v, input int n);
		int i;
		for (i = 0; i < n; i++)
			file_bytes.push_back(v[8 * i +: 8]);
	endtask

	function automatic wav_spec_t plain_spec(input logic [15:0] fmt, input logic [15:0] nch,
		input logic [15:0] bits, input int frames);
		wav_spec_t s;
		int bps;
		bps = (fmt == FMT_FLOAT) ? 4 : int'(bits) / 8;
		s.fmt = fmt;
		s.nch = nch;
		s.bits = bits;
		s.rate = 32'd44100;
		s.align = 16'(int'(nch) * bps);
		s.data_size = 32'(frames * int'(s.align));
		s.payload = frames * int'(nch) * bps;
		s.fmt_size = 32'(FMT_HEAD_BYTES);
		s.chunks = 0;
		s.tag_break = 0;
		s.cut = -1;
		s.eos = 1'b1;
		return s;
	endfunction

	task automatic open_file(input wav_spec_t s);
		logic [31:0] id;
		int i;
		int c;
		int sz;
		file_bytes.delete();
		put_le((s.tag_break == 1) ? TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)) : TAG_RIFF, 4);
		put_le($urandom, 4);
		put_le((s.tag_break == 2) ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)) : TAG_WAVE, 4);
		put_le($urandom, 4);
		put_le(s.fmt_size, 4);
		put_le(32'(s.fmt), 2);
		put_le(32'(s.nch), 2);
		put_le(s.rate, 4);
		put_le($urandom, 4);
		put_le(32'(s.align), 2);
		put_le(32'(s.bits), 2);
		for (i = 16; i < s.fmt_size && i < 56; i++)
			put_le($urandom, 1);
		for (c = 0; c < s.chunks; c++) begin
			id = $urandom;
			if (id == TAG_DATA)
				id = ~id;
			sz = $urandom_range(0, 5);
			put_le(id, 4);
			put_le(sz, 4);
			for (i = 0; i < sz; i++)
				put_le($urandom, 1);
		end
		put_le(TAG_DATA, 4);
		put_le(s.data_size, 4);
	endtask

	task automatic close_file(input wav_spec_t s);
		int i;
		int n;
		for (i = 0; i < s.payload; i++)
			put_le($urandom, 1);
		n = file_bytes.size();
		if (s.cut > 0 && s.cut < n)
			n = s.cut;
		for (i = 0; i < n; i++)
			pending_bytes.push_back('{data: file_bytes[i], first: (i == 0),
				eos: (s.eos && i == n - 1)});
	endtask

	// request driver
	always @(negedge clk) begin : drive_bytes
		byte_req_t req;
		if (!arst_n) begin
			stream_ch.valid <= 1'b0;
			stream_ch.data_byte <= '0;
			stream_ch.first_byte <= 1'b0;
			stream_ch.end_of_stream <= 1'b0;
		end else if (!stream_ch.valid || byte_taken) begin
			if (send_gap > 0) begin
				stream_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_bytes.size() > 0) begin
				req = pending_bytes.pop_front();
				stream_ch.valid <= 1'b1;
				stream_ch.data_byte <= req.data;
				stream_ch.first_byte <= req.first;
				stream_ch.end_of_stream <= req.eos;
				send_gap <= (!send_quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end else begin
				stream_ch.valid <= 1'b0;
			end
		end
		if ($urandom_range(0, 399) == 0)
			send_quiet <= !send_quiet;
	end

	// result receiver with random stalls and long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_marks < 2 && results_seen >= 60 + 200 * hold_marks) begin
			result_ch.ready <= 1'b0;
			hold_left <= 300;
			hold_marks <= hold_marks + 1;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_ch.ready <= 1'b1;
			stall_left <= (!recv_quiet && $urandom_range(0, 4) == 0) ? pick_gap() : 0;
		end
		if ($urandom_range(0, 399) == 0)
			recv_quiet <= !recv_quiet;
	end

	// monitor and checker
	always @(posedge clk) begin : watch
		wave_result_t want;
		if (!arst_n) begin
			byte_taken <= 1'b0;
			clear_parser();
		end else begin
			byte_taken <= stream_ch.valid && stream_ch.ready;
			if (stream_ch.valid && stream_ch.ready) begin
				decode_byte(stream_ch.data_byte, stream_ch.first_byte, stream_ch.end_of_stream);
				bytes_taken++;
			end
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: kind %0d", result_ch.result_kind);
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("result_kind", want.kind, result_ch.result_kind);
					check_field("error_code", want.err, result_ch.error_code);
					check_field("channel_total", want.chan_total, result_ch.channel_total);
					check_field("rate_hz", want.rate, result_ch.rate_hz);
					check_field("frame_total", want.frames, result_ch.frame_total);
					check_field("channel_index", want.chan_idx, result_ch.channel_index);
					check_field("frame_index", want.frame_idx, result_ch.frame_index);
					check_field("pcm_value", want.pcm, result_ch.pcm_value);
					check_field("float_bits", want.fbits, result_ch.float_bits);
					check_field("is_float", want.isf, result_ch.is_float);
					check_field("last_sample", want.last, result_ch.last_sample);
				end
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		wav_spec_t s;
		logic [15:0] fmt_sel;
		logic [15:0] nch_sel;
		logic [15:0] bits_sel;
		int pick;
		int i;
		int n;
		int directed_count;

		arst_n = 1'b0;

		// pcm extremes at every depth
		s = plain_spec(FMT_PCM, 16'd1, 16'd8, 4);
		s.payload = 0;
		open_file(s);
		put_le(32'h7FFF_8000, 4);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd2, 16'd16, 2);
		s.payload = 0;
		open_file(s);
		put_le(32'h7FFF_8000, 4);
		put_le(32'hFFFF_0000, 4);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd1, 16'd24, 2);
		s.payload = 0;
		open_file(s);
		put_le(32'h0080_0000, 3);
		put_le(32'h007F_FFFF, 3);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd1, 16'd32, 3);
		s.payload = 0;
		open_file(s);
		put_le(32'h8000_0000, 4);
		put_le(32'h7FFF_FFFF, 4);
		put_le(32'hFFFF_FFFF, 4);
		close_file(s);
		// float, including a bits field that is not 32
		s = plain_spec(FMT_FLOAT, 16'd2, 16'd32, 2);
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_FLOAT, 16'd1, 16'd16, 1);
		open_file(s);
		close_file(s);
		// tag errors
		s = plain_spec(FMT_PCM, 16'd1, 16'd8, 2);
		s.tag_break = 1;
		open_file(s);
		close_file(s);
		s.tag_break = 2;
		open_file(s);
		close_file(s);
		// depth and format errors
		s = plain_spec(FMT_PCM, 16'd1, 16'd33, 2);
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd1, 16'hFFFF, 2);
		s.payload = 0;
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd1, 16'd12, 2);
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd1, 16'd0, 2);
		open_file(s);
		close_file(s);
		s = plain_spec(16'd2, 16'd1, 16'd16, 2);
		open_file(s);
		close_file(s);
		s = plain_spec(16'hFFFF, 16'd1, 16'd16, 2);
		s.payload = 0;
		open_file(s);
		close_file(s);
		// early end inside fmt and on the very first byte
		s = plain_spec(FMT_PCM, 16'd1, 16'd16, 2);
		s.cut = 30;
		open_file(s);
		close_file(s);
		s.cut = 1;
		open_file(s);
		close_file(s);
		// end on the byte that completes the data size
		s = plain_spec(FMT_PCM, 16'd1, 16'd16, 3);
		s.payload = 0;
		open_file(s);
		close_file(s);
		// zero block align, zero frames, zero channels
		s = plain_spec(FMT_PCM, 16'd1, 16'd16, 2);
		s.align = 16'd0;
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd2, 16'd16, 0);
		s.payload = 3;
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd0, 16'd16, 0);
		s.align = 16'd2;
		s.data_size = 32'd4;
		s.payload = 4;
		open_file(s);
		close_file(s);
		// block align that does not match the sample size
		s = plain_spec(FMT_PCM, 16'd2, 16'd16, 0);
		s.align = 16'd3;
		s.data_size = 32'd12;
		s.payload = 16;
		open_file(s);
		close_file(s);
		// extra fmt bytes, short fmt size, odd chunk sizes
		s = plain_spec(FMT_PCM, 16'd1, 16'd8, 2);
		s.fmt_size = 32'd19;
		s.chunks = 2;
		open_file(s);
		close_file(s);
		s.fmt_size = 32'd10;
		s.chunks = 1;
		open_file(s);
		close_file(s);
		s.fmt_size = 32'hFFFF_FFFF;
		s.chunks = 0;
		s.cut = 60;
		open_file(s);
		close_file(s);
		// end during samples, huge frame count, widest channel count and rate
		s = plain_spec(FMT_PCM, 16'd1, 16'd16, 4);
		s.payload = 3;
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd1, 16'd8, 0);
		s.align = 16'd1;
		s.data_size = 32'hFFFF_FFFF;
		s.payload = 5;
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'hFFFF, 16'd8, 0);
		s.rate = 32'hFFFF_FFFF;
		s.align = 16'd1;
		s.data_size = 32'd3;
		s.payload = 3;
		open_file(s);
		close_file(s);
		// restart in the middle of a file, then trailing bytes after the last sample
		s = plain_spec(FMT_PCM, 16'd1, 16'd16, 2);
		s.cut = 20;
		s.eos = 1'b0;
		open_file(s);
		close_file(s);
		s = plain_spec(FMT_PCM, 16'd2, 16'd8, 2);
		s.payload = 8;
		open_file(s);
		close_file(s);

		directed_count = pending_bytes.size();
		while (pending_bytes.size() < directed_count + 150) begin
			if ($urandom_range(0, 29) == 0) begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					pending_bytes.push_back('{data: 8'($urandom),
						first: ($urandom_range(0, 3) == 0), eos: ($urandom_range(0, 3) == 0)});
			end else begin
				pick = $urandom_range(0, 99);
				fmt_sel = (pick < 85) ? FMT_PCM : (pick < 95) ? FMT_FLOAT : 16'($urandom);
				pick = $urandom_range(0, 99);
				if (fmt_sel == FMT_FLOAT)
					bits_sel = (pick < 80) ? 16'd32 : 16'($urandom_range(0, 40));
				else
					bits_sel = (pick < 90) ? 16'(8 * $urandom_range(1, 4)) :
						(pick < 98) ? 16'($urandom_range(0, 40)) : 16'($urandom);
				pick = $urandom_range(0, 99);
				nch_sel = (pick < 94) ? 16'($urandom_range(1, 3)) :
					(pick < 97) ? 16'd0 : 16'($urandom);
				s = plain_spec(fmt_sel, nch_sel, bits_sel, $urandom_range(0, 5));
				s.rate = $urandom;
				if ($urandom_range(0, 99) < 8)
					s.align = 16'($urandom_range(0, 8));
				if ($urandom_range(0, 99) < 5)
					s.data_size = $urandom;
				if ($urandom_range(0, 99) < 10)
					s.payload = s.payload + $urandom_range(1, 4);
				else if ($urandom_range(0, 99) < 8)
					s.payload = $urandom_range(0, s.payload);
				if (s.payload > 48)
					s.payload = 48;
				pick = $urandom_range(0, 99);
				if (pick < 15)
					s.fmt_size = 32'($urandom_range(17, 22));
				else if (pick < 20)
					s.fmt_size = 32'($urandom_range(0, 15));
				if ($urandom_range(0, 3) == 0)
					s.chunks = $urandom_range(1, 2);
				pick = $urandom_range(0, 99);
				s.tag_break = (pick < 3) ? 1 : (pick < 6) ? 2 : 0;
				if ($urandom_range(0, 99) < 6)
					s.cut = $urandom_range(1, 60);
				s.eos = ($urandom_range(0, 99) < 97);
				open_file(s);
				close_file(s);
			end
		end
		total_bytes = pending_bytes.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (bytes_taken == total_bytes);
		wait (awaited_results.size() == 0);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[wave_stream_decoder.f]
hdl/wsd_pkg.sv
hdl/wsd_in_if.sv
hdl/wsd_out_if.sv
hdl/wsd_div.sv
hdl/wsd_front.sv
hdl/wsd_fifo.sv
hdl/wsd_back.sv
hdl/wave_stream_decoder.sv
dv/wave_stream_decoder_tb.sv
